@@ rtl/core/tbi_pkg.sv @@
// shared types and constants for the timestamp bracket interpolator
package tbi_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int TIME_W        = 52;
   localparam int POS_W         = 32;
   localparam int GAP_W         = 26;
   localparam int PROD_W        = POS_W + GAP_W;
   localparam int IDX_W         = 10;
   localparam int REQ_DATA_W    = 152;
   localparam int RSP_DATA_W    = 112;
   localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(2000000);

   typedef enum logic [1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STS_DONE    = 2'd0,
      STS_FULL    = 2'd1,
      STS_MATCH   = 2'd2,
      STS_UNMATCH = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_GAP,
      ST_CHECK,
      ST_DIFF,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_ACC,
      ST_FIN
   } tbi_state_type;

   typedef struct packed {
      logic [TIME_W-1:0]       time_us;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } row_type;

endpackage

@@ rtl/core/timestamp_bracket_interpolator.sv @@
// Timestamp bracket interpolator: a table of timestamped positions with clear, append and
// query requests. A query reads the table once entry by entry through its single read port
// up to the bracketing sample, checks the gaps, then runs each of the three axes through
// one shared multiplier and a one-bit-per-cycle divider. The block takes no request while
// one is in work; a finished result waits in the output register.
module timestamp_bracket_interpolator
   import tbi_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // time_us, in_x, in_y, in_z
   input  logic [1:0]            req_tuser,  // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // out_x, out_y, out_z, lower_index
   output logic [1:0]            rsp_tuser,  // status
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   tbi_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [GAP_W-1:0] gap_ff;
   logic [TIME_W-1:0] qtime_ff, qtime_in;
   logic [CW-1:0]  rd_idx_ff, rd_idx_in;
   logic [CW-1:0]  chk_idx_ff, chk_idx_in;
   logic           pend_ff, pend_in;
   logic [AW-1:0]  lo_idx_ff, lo_idx_in;
   row_type        prev_ff, prev_in, cur_ff, cur_in;
   logic [TIME_W-1:0] num_ff, num_in, hi_ff, hi_in, den_ff, den_in;
   logic [1:0]     axis_ff, axis_in;
   logic           neg_ff, neg_in;
   logic [POS_W-1:0] mag_ff, mag_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic signed [POS_W-1:0] res_ff [3];
   logic signed [POS_W-1:0] res_in [3];
   status_type     status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type     rsp_sts_ff, rsp_sts_in;

   logic           accept, wr_en, issue, div_start, div_done;
   logic [PROD_W-1:0] quo;
   row_type        rd_row, wr_row;
   logic signed [POS_W-1:0] v1, v2;
   logic [POS_W:0] diff, diff_abs;
   logic [AW+IDX_W-1:0] lo_wide;
   logic           csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32 - GAP_W){1'b0}}, gap_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_RESET;
      end else if (csr_wr) begin
         gap_ff <= csr_pwdata[GAP_W-1:0];
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid & req_tready;
   assign issue      = rd_idx_ff < count_ff;

   assign wr_row.time_us = req_tdata[TIME_W-1:0];
   assign wr_row.pos_x   = req_tdata[TIME_W +: POS_W];
   assign wr_row.pos_y   = req_tdata[TIME_W + POS_W +: POS_W];
   assign wr_row.pos_z   = req_tdata[TIME_W + 2*POS_W +: POS_W];
   assign wr_en = accept && req_kind_type'(req_tuser) == REQ_APPEND
                  && count_ff != CW'(TABLE_DEPTH);

   tbi_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_row),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_row)
   );

   tbi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      unique case (axis_ff)
         2'd0: begin
            v1 = prev_ff.pos_x;
            v2 = cur_ff.pos_x;
         end
         2'd1: begin
            v1 = prev_ff.pos_y;
            v2 = cur_ff.pos_y;
         end
         default: begin
            v1 = prev_ff.pos_z;
            v2 = cur_ff.pos_z;
         end
      endcase
   end

   assign diff     = {v2[POS_W-1], v2} - {v1[POS_W-1], v1};
   assign diff_abs = diff[POS_W] ? -diff : diff;
   assign lo_wide  = {{IDX_W{1'b0}}, lo_idx_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      qtime_in     = qtime_ff;
      rd_idx_in    = rd_idx_ff;
      chk_idx_in   = chk_idx_ff;
      pend_in      = pend_ff;
      lo_idx_in    = lo_idx_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      num_in       = num_ff;
      hi_in        = hi_ff;
      den_in       = den_ff;
      axis_in      = axis_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_sts_in   = rsp_sts_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               qtime_in   = req_tdata[TIME_W-1:0];
               res_in[0]  = '0;
               res_in[1]  = '0;
               res_in[2]  = '0;
               lo_idx_in  = '0;
               axis_in    = 2'd0;
               rd_idx_in  = '0;
               chk_idx_in = '0;
               pend_in    = 1'b0;
               status_in  = STS_DONE;
               state_in   = ST_FIN;
               case (req_kind_type'(req_tuser))
                  REQ_CLEAR: count_in = '0;
                  REQ_APPEND: begin
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        status_in = STS_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_QUERY: begin
                     status_in = STS_UNMATCH;
                     state_in  = ST_SCAN;
                  end
                  default: status_in = STS_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (pend_ff && rd_row.time_us > qtime_ff) begin
               cur_in    = rd_row;
               lo_idx_in = AW'(chk_idx_ff - 1'b1);
               pend_in   = 1'b0;
               state_in  = (chk_idx_ff == '0) ? ST_FIN : ST_GAP;
            end else if (pend_ff) begin
               prev_in    = rd_row;
               chk_idx_in = chk_idx_ff + 1'b1;
               pend_in    = issue;
               if (issue) rd_idx_in = rd_idx_ff + 1'b1;
            end else if (!issue) begin
               state_in = ST_FIN;
            end else begin
               pend_in   = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         ST_GAP: begin
            num_in   = qtime_ff - prev_ff.time_us;
            hi_in    = cur_ff.time_us - qtime_ff;
            den_in   = cur_ff.time_us - prev_ff.time_us;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (num_ff <= TIME_W'(gap_ff) && hi_ff <= TIME_W'(gap_ff)) begin
               state_in = ST_DIFF;
            end else begin
               lo_idx_in = '0;
               state_in  = ST_FIN;
            end
         end
         ST_DIFF: begin
            neg_in   = diff[POS_W];
            mag_in   = diff_abs[POS_W-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mag_ff) * PROD_W'(num_ff[GAP_W-1:0]);
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) state_in = ST_ACC;
         end
         ST_ACC: begin
            res_in[axis_ff] = neg_ff ? v1 - $signed(quo[POS_W-1:0])
                                     : v1 + $signed(quo[POS_W-1:0]);
            if (axis_ff == 2'd2) begin
               status_in = STS_MATCH;
               state_in  = ST_FIN;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_sts_in   = status_ff;
               rsp_data_in  = '0;
               if (status_ff == STS_MATCH) begin
                  rsp_data_in = {{(RSP_DATA_W - 3*POS_W - IDX_W){1'b0}},
                                 lo_wide[IDX_W-1:0], res_ff[2], res_ff[1], res_ff[0]};
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qtime_ff    <= qtime_in;
      rd_idx_ff   <= rd_idx_in;
      chk_idx_ff  <= chk_idx_in;
      lo_idx_ff   <= lo_idx_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      num_ff      <= num_in;
      hi_ff       <= hi_in;
      den_ff      <= den_in;
      axis_ff     <= axis_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sts_ff  <= rsp_sts_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sts_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("sample count beyond table depth");

   a_zero_unless_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sts_ff != STS_MATCH |-> rsp_data_ff == '0)
      else $error("unmatched request carries data");

   a_div_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && !rsp_valid_ff |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished request not loaded into output");
`endif

endmodule

@@ rtl/core/tbi_table.sv @@
// sample table memory, one write port and one registered read port
module tbi_table
   import tbi_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  row_type       wr_data,
   input  logic [AW-1:0] rd_addr,
   output row_type       rd_data
);

   row_type mem [DEPTH];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tbi_div.sv @@
// restoring divider, one quotient bit per cycle
module tbi_div
   import tbi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic [PROD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic [TIME_W:0]   rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [TIME_W:0]   rem_sh;
   logic              take;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[TIME_W-1:0], quo_ff[PROD_W-1]};
      take    = rem_sh >= {1'b0, div_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = CNT_W'(PROD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = take ? rem_sh - {1'b0, div_ff} : rem_sh;
         quo_in = {quo_ff[PROD_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
